// ===== hw/rtl/pal_pkg.sv =====
`timescale 1ns / 1ps

package pal_pkg;

    // Default list capacity.
    localparam int PAL_DEPTH = 128;

    // Width of one group in the first level of the match encoder.
    localparam int PAL_GROUP = 16;
    localparam int PAL_GROUP_W = $clog2(PAL_GROUP);

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_UPDATE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_SCAN,
        FSM_PICK,
        FSM_HOLD
    } fsm_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        op_t  op;
        logic commit;
    } cell_cmd_t;

endpackage

// ===== hw/rtl/pal_cell.sv =====
`timescale 1ns / 1ps

// One list slot. It takes its left neighbor on an insert above the target
// position, its right neighbor on a delete at or above it, and the new value
// at the target itself. It also registers whether it holds a live match.
module pal_cell #(
    parameter int DEPTH = pal_pkg::PAL_DEPTH,
    parameter int IDX   = 0
) (
    input  logic                            aclk,
    input  pal_pkg::cell_cmd_t              cmd,
    input  logic [$clog2(DEPTH)-1:0]        p_idx,
    input  logic [$clog2(DEPTH+1)-1:0]      n,
    input  logic signed [31:0]              value,
    input  logic signed [31:0]              left_data,
    input  logic signed [31:0]              right_data,
    output logic signed [31:0]              data,
    output logic                            match
);
    import pal_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] ME_I = IW'(IDX);
    localparam logic [CW-1:0] ME_C = CW'(IDX);

    logic signed [31:0] data_reg;
    logic signed [31:0] data_next;
    logic               match_reg;
    logic               match_next;

    always_comb begin
        data_next = data_reg;
        if (cmd.commit) begin
            case (cmd.op)
                OP_INSERT: begin
                    if (ME_I > p_idx) begin
                        data_next = left_data;
                    end else if (ME_I == p_idx) begin
                        data_next = value;
                    end
                end
                OP_DELETE: begin
                    if (ME_I >= p_idx) begin
                        data_next = right_data;
                    end
                end
                OP_UPDATE: begin
                    if (ME_I == p_idx) begin
                        data_next = value;
                    end
                end
                default: begin
                    data_next = data_reg;
                end
            endcase
        end
    end

    assign match_next = (ME_C < n) && (data_reg == value);

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// ===== hw/rtl/pal_enc.sv =====
`timescale 1ns / 1ps

// First-match encoder in two levels: a registered per-group search, then a
// pick of the lowest group that has a hit.
module pal_enc #(
    parameter int DEPTH = pal_pkg::PAL_DEPTH
) (
    input  logic                        aclk,
    input  logic [DEPTH-1:0]            hits,
    output logic                        found,
    output logic [$clog2(DEPTH)-1:0]    index
);
    import pal_pkg::*;

    localparam int IW  = $clog2(DEPTH);
    localparam int NG  = (DEPTH + PAL_GROUP - 1) / PAL_GROUP;
    localparam int NGW = (NG > 1) ? $clog2(NG) : 1;

    logic [NG*PAL_GROUP-1:0] padded;
    logic [NG-1:0]           any_reg;
    logic [NG-1:0]           any_next;
    logic [PAL_GROUP_W-1:0]  off_reg  [NG];
    logic [PAL_GROUP_W-1:0]  off_next [NG];
    logic [NGW-1:0]          sel_grp;
    logic [PAL_GROUP_W-1:0]  sel_off;

    assign padded = (NG*PAL_GROUP)'(hits);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            any_next[g] = |padded[g*PAL_GROUP +: PAL_GROUP];
            off_next[g] = '0;
            for (int b = PAL_GROUP - 1; b >= 0; b--) begin
                if (padded[g*PAL_GROUP + b]) begin
                    off_next[g] = PAL_GROUP_W'(b);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        any_reg <= any_next;
        for (int g = 0; g < NG; g++) begin
            off_reg[g] <= off_next[g];
        end
    end

    always_comb begin
        sel_grp = '0;
        sel_off = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (any_reg[g]) begin
                sel_grp = NGW'(g);
                sel_off = off_reg[g];
            end
        end
    end

    assign found = |any_reg;
    assign index = IW'({sel_grp, sel_off});

endmodule

// ===== hw/rtl/positional_array_list_unit.sv =====
`timescale 1ns / 1ps

// Insert, delete and update: the cell row takes its single shift step in the execute state,
// and the result beat goes to the output register, or to the pending slot while that is occupied.
// Search: the result comes from the registered match bits and the two-level first-match
// encoder, in the scan and pick states. Input ready is high only in the idle state.
// Synchronous active-low reset empties the list (count zero); stored values are not cleared.
module positional_array_list_unit #(
    parameter int DEPTH = pal_pkg::PAL_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_func,
    input  logic [7:0]          s_position,
    input  logic signed [31:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_status,
    output logic [6:0]          m_found_index,
    output logic [7:0]          m_count
);
    import pal_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // Wide enough to compare a position against the count plus one.
    localparam int WW = ((CW > 8) ? CW : 8) + 1;

    // Control state.
    fsm_t           state_reg;
    fsm_t           state_next;
    logic [CW-1:0]  n_reg;
    logic [CW-1:0]  n_next;

    // The accepted request is held for the whole operation.
    op_t                func_reg;
    logic [7:0]         pos_reg;
    logic signed [31:0] value_reg;

    // Output register and the pending slot used when the output is still occupied.
    logic           m_valid_reg;
    logic           m_valid_next;
    status_t        status_out_reg;
    logic [6:0]     index_out_reg;
    logic [7:0]     count_out_reg;
    status_t        pend_status_reg;
    logic [6:0]     pend_index_reg;

    // Decode of the request against the current count.
    status_t        exec_status;
    logic           exec_ok;
    logic [WW-1:0]  pos_w;
    logic [WW-1:0]  n_w;
    logic [IW-1:0]  p_idx;

    // Cell row and encoder.
    cell_cmd_t          cmd;
    logic signed [31:0] cell_data [DEPTH];
    logic [DEPTH-1:0]   hits;
    logic               enc_found;
    logic [IW-1:0]      enc_index;

    // Controller outputs.
    logic           out_free;
    logic           load_out;
    logic           load_pend;
    status_t        res_status;
    logic [6:0]     res_index;

    assign out_free = !m_valid_reg || m_ready;
    assign pos_w    = WW'(pos_reg);
    assign n_w      = WW'(n_reg);
    // Only used once the position has been checked, so the wrap at zero is harmless.
    assign p_idx    = IW'(pos_reg - 8'd1);

    // Status checks follow the list rules: fullness before position on insert,
    // emptiness before position on delete.
    always_comb begin
        exec_status = ST_OK;
        case (func_reg)
            OP_INSERT: begin
                if (n_reg == CW'(DEPTH)) begin
                    exec_status = ST_FULL;
                end else if (pos_reg == 8'd0 || pos_w > n_w + WW'(1)) begin
                    exec_status = ST_BADPOS;
                end
            end
            OP_DELETE: begin
                if (n_reg == '0) begin
                    exec_status = ST_EMPTY;
                end else if (pos_reg == 8'd0 || pos_w > n_w) begin
                    exec_status = ST_BADPOS;
                end
            end
            OP_UPDATE: begin
                if (pos_reg == 8'd0 || pos_w > n_w) begin
                    exec_status = ST_BADPOS;
                end
            end
            default: begin
                exec_status = ST_OK;
            end
        endcase
    end

    assign exec_ok    = (exec_status == ST_OK);
    assign cmd.op     = func_reg;
    assign cmd.commit = (state_reg == FSM_EXEC) && exec_ok && (func_reg != OP_SEARCH);

    always_comb begin
        n_next = n_reg;
        if (cmd.commit) begin
            case (func_reg)
                OP_INSERT: n_next = n_reg + CW'(1);
                OP_DELETE: n_next = n_reg - CW'(1);
                default:   n_next = n_reg;
            endcase
        end
    end

    // Row of cells: each one sees both neighbors, the ends see zero.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [31:0] left_data;
        logic signed [31:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_inner_l
            assign left_data = cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_inner_r
            assign right_data = cell_data[g+1];
        end

        pal_cell #(
            .DEPTH (DEPTH),
            .IDX   (g)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .p_idx      (p_idx),
            .n          (n_reg),
            .value      (value_reg),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[g]),
            .match      (hits[g])
        );
    end

    pal_enc #(
        .DEPTH (DEPTH)
    ) u_enc (
        .aclk  (aclk),
        .hits  (hits),
        .found (enc_found),
        .index (enc_index)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (func_reg == OP_SEARCH) begin
                    state_next = FSM_SCAN;
                end else if (out_free) begin
                    state_next = FSM_IDLE;
                end else begin
                    state_next = FSM_HOLD;
                end
            end
            FSM_SCAN: begin
                state_next = FSM_PICK;
            end
            FSM_PICK: begin
                state_next = out_free ? FSM_IDLE : FSM_HOLD;
            end
            FSM_HOLD: begin
                state_next = out_free ? FSM_IDLE : FSM_HOLD;
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Controller outputs: where the result comes from and where it goes.
    always_comb begin
        load_out   = 1'b0;
        load_pend  = 1'b0;
        res_status = ST_OK;
        res_index  = '0;
        case (state_reg)
            FSM_EXEC: begin
                res_status = exec_status;
                if (func_reg != OP_SEARCH) begin
                    load_out  = out_free;
                    load_pend = !out_free;
                end
            end
            FSM_PICK: begin
                res_status = enc_found ? ST_OK : ST_NOTFOUND;
                res_index  = enc_found ? 7'(enc_index) : 7'd0;
                load_out   = out_free;
                load_pend  = !out_free;
            end
            FSM_HOLD: begin
                res_status = pend_status_reg;
                res_index  = pend_index_reg;
                load_out   = out_free;
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg  <= op_t'(s_func);
            pos_reg   <= s_position;
            value_reg <= s_value;
        end
        if (load_out) begin
            status_out_reg <= res_status;
            index_out_reg  <= res_index;
            count_out_reg  <= 8'(n_next);
        end
        if (load_pend) begin
            pend_status_reg <= res_status;
            pend_index_reg  <= res_index;
        end
    end

    assign s_ready       = (state_reg == FSM_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = status_out_reg;
    assign m_found_index = index_out_reg;
    assign m_count       = count_out_reg;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

    import pal_pkg::*;

    localparam int LIST_DEPTH  = PAL_DEPTH;
    // The receiver stops taking results for this long while items keep arriving.
    localparam int HOLD_CYCLES = 120;
    // Far beyond the slowest legal run: about 800 beats, each at worst a search
    // with a sender gap and a receiver stall pattern, plus the long hold-off.
    localparam int CYCLE_LIMIT = 100000;

    // One result beat as the block reports it.
    typedef struct packed {
        status_t    status;
        logic [6:0] found_index;
        logic [7:0] count;
    } list_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_func;
    logic [7:0]         s_position;
    logic signed [31:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_status;
    logic [6:0]         m_found_index;
    logic [7:0]         m_count;

    positional_array_list_unit #(
        .DEPTH(LIST_DEPTH)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_position   (s_position),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_found_index(m_found_index),
        .m_count      (m_count)
    );

    // Shadow copy of the list. Only the first shadow_count entries are ever read.
    logic signed [31:0] shadow_list [0:LIST_DEPTH-1];
    int                 shadow_count;

    // Results the block still owes us, oldest first.
    list_result_t pending_results [$];

    int  mismatch_count;
    int  cycle_count = 0;
    bit  hold_request;
    int  burst_left;

    // The clock runs from time zero with a 12 ns period.
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Apply one request to the shadow list and return the result beat it should
    // produce. Failed requests leave the list and the count untouched, and
    // found_index is zero for everything except a successful search.
    task automatic apply_request(input op_t op, input logic [7:0] pos,
                                 input logic signed [31:0] val,
                                 output list_result_t res);
        int p;
        int i;
        p = int'(pos);
        res.status      = ST_OK;
        res.found_index = '0;
        case (op)
            OP_INSERT: begin
                // Fullness is checked before the position.
                if (shadow_count >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else if (p < 1 || p > shadow_count + 1) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (i = shadow_count; i >= p; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p-1] = val;
                    shadow_count++;
                end
            end
            OP_DELETE: begin
                // Emptiness is checked before the position.
                if (shadow_count == 0) begin
                    res.status = ST_EMPTY;
                end else if (p < 1 || p > shadow_count) begin
                    res.status = ST_BADPOS;
                end else begin
                    for (i = p - 1; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_count--;
                end
            end
            OP_SEARCH: begin
                // First match wins; an empty list simply finds nothing.
                res.status = ST_NOTFOUND;
                for (i = 0; i < shadow_count; i++) begin
                    if (res.status == ST_NOTFOUND && shadow_list[i] == val) begin
                        res.status      = ST_OK;
                        res.found_index = i[6:0];
                    end
                end
            end
            default: begin
                // Update covers the empty list too: every position is out of range.
                if (p < 1 || p > shadow_count)
                    res.status = ST_BADPOS;
                else
                    shadow_list[p-1] = val;
            end
        endcase
        res.count = shadow_count[7:0];
    endtask

    // Send one beat. The payload changes at the falling edge and the beat counts
    // as taken at the first rising edge where ready is high. Beats go out in
    // bursts: valid stays high from one beat to the next inside a burst, and
    // drops for a random gap between bursts.
    task automatic send_beat(input op_t op, input logic [7:0] pos,
                             input logic signed [31:0] val);
        list_result_t res;
        @(negedge aclk);
        s_valid    = 1'b1;
        s_func     = op;
        s_position = pos;
        s_value    = val;
        do @(posedge aclk); while (!s_ready);
        apply_request(op, pos, val, res);
        pending_results.push_back(res);
        if (burst_left == 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge aclk);
            // Now and then a long burst, so stretches with no sender gaps occur.
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 10);
        end else begin
            burst_left--;
        end
    endtask

    // Values lean toward live entries and a small cluster around zero, so that
    // searches hit and duplicates exist; the rest cover every bit at random.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return (shadow_count > 0) ?
                            shadow_list[$urandom_range(0, shadow_count - 1)] : $urandom;
            1:       return $signed($urandom_range(0, 7)) - 4;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a legal position for the operation, sometimes anything at all.
    function automatic logic [7:0] pick_position(input op_t op);
        int top;
        top = (op == OP_INSERT) ? shadow_count + 1 : shadow_count;
        if (top < 1 || $urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(1, top));
    endfunction

    task automatic note_mismatch(input string what, input list_result_t want,
                                 input list_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $write("tb: %s at cycle %0d: expected status %0d index %0d count %0d,",
                   what, cycle_count, want.status, want.found_index, want.count);
            $display(" got status %0d index %0d count %0d",
                     got.status, got.found_index, got.count);
        end
    endtask

    // Result checker: every accepted result beat is compared, field by field,
    // with the oldest pending expectation.
    always @(posedge aclk) begin
        list_result_t want;
        list_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.status      = status_t'(m_status);
            got.found_index = m_found_index;
            got.count       = m_count;
            if (pending_results.size() == 0) begin
                want = '0;
                note_mismatch("result beat with nothing pending", want, got);
            end else begin
                want = pending_results.pop_front();
                if (got.status != want.status)
                    note_mismatch("status mismatch", want, got);
                else if (got.found_index != want.found_index)
                    note_mismatch("found_index mismatch", want, got);
                else if (got.count != want.count)
                    note_mismatch("count mismatch", want, got);
            end
        end
    end

    // Receiver: ready follows a pattern that changes at random intervals:
    // always ready, a coin toss each cycle, or a periodic pulse from a stall counter. When a
    // hold-off is requested it keeps ready low for the span set by HOLD_CYCLES.
    initial begin
        int ready_mode;
        int phase_left;
        int stall_tick;
        ready_mode = 0;
        phase_left = 0;
        stall_tick = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end else begin
                if (phase_left == 0) begin
                    ready_mode = $urandom_range(0, 2);
                    phase_left = $urandom_range(8, 64);
                end
                phase_left--;
                stall_tick++;
                case (ready_mode)
                    0:       m_ready = 1'b1;
                    1:       m_ready = 1'($urandom_range(0, 1));
                    default: m_ready = (stall_tick % 4 == 0);
                endcase
            end
        end
    end

    // Corner cases on a short list: the empty, bad-position and not-found statuses, the extreme values,
    // and positions just outside the legal range on both sides.
    task automatic test_short_list();
        send_beat(OP_DELETE, 8'd1, 32'sd5);          // empty list
        send_beat(OP_DELETE, 8'd0, 32'sd0);          // empty wins over a bad position
        send_beat(OP_UPDATE, 8'd1, 32'sd9);          // nothing to update yet
        send_beat(OP_SEARCH, 8'd0, 32'sd0);          // search of an empty list
        send_beat(OP_INSERT, 8'd0, 32'sd1);          // position zero
        send_beat(OP_INSERT, 8'd2, 32'sd1);          // one past count + 1
        send_beat(OP_INSERT, 8'd1, 32'h8000_0000);   // most negative value
        send_beat(OP_INSERT, 8'd2, 32'h7fff_ffff);   // append, most positive value
        send_beat(OP_INSERT, 8'd1, 32'sd0);          // insert at the head
        send_beat(OP_INSERT, 8'd255, 32'sd3);        // far out of range
        send_beat(OP_INSERT, 8'd2, 32'sd0);          // duplicate value in the middle
        send_beat(OP_SEARCH, 8'd255, 32'sd0);        // first of two matches
        send_beat(OP_SEARCH, 8'd0, 32'h7fff_ffff);   // last entry
        send_beat(OP_SEARCH, 8'd1, -32'sd1);         // no match
        send_beat(OP_UPDATE, 8'd4, -32'sd1);         // last live position
        send_beat(OP_UPDATE, 8'd5, 32'sd7);          // one past count
        send_beat(OP_UPDATE, 8'd0, 32'sd7);          // position zero
        send_beat(OP_SEARCH, 8'd0, -32'sd1);
        send_beat(OP_DELETE, 8'd0, 32'sd0);          // position zero
        send_beat(OP_DELETE, 8'd5, 32'sd0);          // one past count
        send_beat(OP_DELETE, 8'd1, 32'sd0);          // head
        send_beat(OP_DELETE, 8'd3, 32'sd0);          // tail
        send_beat(OP_SEARCH, 8'd0, 32'sd0);
    endtask

    // Fill the list to capacity, poke at the full list, then drain it.
    task automatic test_full_list();
        while (shadow_count < LIST_DEPTH)
            send_beat(OP_INSERT, 8'($urandom_range(1, shadow_count + 1)), pick_value());
        // Full is reported ahead of any position check.
        send_beat(OP_INSERT, 8'd0, 32'sd1);
        send_beat(OP_INSERT, 8'd1, 32'sd1);
        send_beat(OP_INSERT, 8'd129, 32'sd1);
        send_beat(OP_INSERT, 8'd255, 32'sd1);
        // A distinctive value in the last slot reaches the highest match index.
        send_beat(OP_UPDATE, 8'd128, 32'h5a5a_a5a5);
        send_beat(OP_SEARCH, 8'd0, 32'h5a5a_a5a5);
        send_beat(OP_UPDATE, 8'd129, 32'sd2);
        send_beat(OP_DELETE, 8'd129, 32'sd0);
        send_beat(OP_DELETE, 8'd128, 32'sd0);
        send_beat(OP_INSERT, 8'd128, pick_value());
        while (shadow_count > 0) begin
            if ($urandom_range(0, 5) == 0)
                send_beat(OP_SEARCH, 8'($urandom_range(0, 255)), pick_value());
            send_beat(OP_DELETE, 8'($urandom_range(1, shadow_count)), $urandom);
        end
        send_beat(OP_DELETE, 8'd1, 32'sd0);
        send_beat(OP_SEARCH, 8'd0, 32'h5a5a_a5a5);
    endtask

    // The receiver holds off while the sender keeps offering beats, so the
    // block backs up and has to drop its input ready.
    task automatic test_output_hold();
        hold_request = 1'b1;
        burst_left   = 40;
        repeat (40) begin
            op_t op;
            op = op_t'($urandom_range(0, 3));
            send_beat(op, pick_position(op), pick_value());
        end
        // The last beat is taken; stop offering it while the hold-off runs out.
        @(negedge aclk);
        s_valid = 1'b0;
        while (hold_request) @(posedge aclk);
    endtask

    // Random mix of all four operations with mostly legal positions.
    task automatic test_random_mix(input int beats);
        repeat (beats) begin
            op_t op;
            int  roll;
            roll = $urandom_range(0, 99);
            if (roll < 35)      op = OP_INSERT;
            else if (roll < 62) op = OP_DELETE;
            else if (roll < 85) op = OP_SEARCH;
            else                op = OP_UPDATE;
            send_beat(op, pick_position(op), pick_value());
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_func         = OP_INSERT;
        s_position     = '0;
        s_value        = '0;
        hold_request   = 1'b0;
        mismatch_count = 0;
        burst_left     = 0;
        shadow_count   = 0;

        // Reset is held low from the start and released at a falling edge.
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_short_list();
        test_full_list();
        test_output_hold();
        test_random_mix(420);

        @(negedge aclk);
        s_valid = 1'b0;

        // Drain everything still owed, then keep the clock running so that any stray
        // result beat shows up in the checker.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
